// ----- design/fac_pkg.sv -----
// Shared types and constants for the frustum box culling core.
package fac_pkg;

   localparam int NUM_PLANES    = 6;
   localparam int NUM_REGS      = 8;
   localparam int REG_W         = 64;
   localparam int REG_IDX_W     = 3;
   localparam int COORD_W       = 32;
   localparam int COEF_W        = COORD_W + 1;
   localparam int PROD_W        = COEF_W + COORD_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int FRAC_W        = 16;
   localparam int DEGEN_MAG_MAX = 6;
   localparam int NORM_SQ_MAX   = 42;

   typedef logic [REG_W-1:0] mat_reg_type;

   localparam mat_reg_type MAT_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      logic [COEF_W-1:0] d;
      logic              degen;
   } plane_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage

// ----- design/fac_plane_gen.sv -----
// Matrix registers and registered frustum plane coefficients.
module fac_plane_gen (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write,
   input  logic [fac_pkg::REG_IDX_W-1:0]              csr_index,
   input  logic [fac_pkg::REG_W-1:0]                  csr_wdata,
   output fac_pkg::plane_type [fac_pkg::NUM_PLANES-1:0] planes
);
   import fac_pkg::*;

   localparam logic signed [COEF_W-1:0] DEGEN_HI = COEF_W'(DEGEN_MAG_MAX);
   localparam logic signed [COEF_W-1:0] DEGEN_LO = -DEGEN_HI;

   mat_reg_type mat_ff [NUM_REGS];
   logic signed [COEF_W-1:0] elem [4][4];
   logic signed [COEF_W-1:0] coef [NUM_PLANES][4];
   logic [COEF_W-1:0] neg_val [NUM_PLANES][3];
   logic [2:0] mag3 [NUM_PLANES][3];
   logic [5:0] sq [NUM_PLANES][3];
   logic [6:0] norm_sq [NUM_PLANES];
   logic [NUM_PLANES-1:0] small_ok;
   plane_type [NUM_PLANES-1:0] planes_in;
   plane_type [NUM_PLANES-1:0] planes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            mat_ff[i] <= MAT_RESET[i];
         end
      end else if (csr_write) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (r % 2 == 1) begin
               elem[r][c] = $signed({mat_ff[2*c + r/2][REG_W-1],
                                     mat_ff[2*c + r/2][REG_W-1:COORD_W]});
            end else begin
               elem[r][c] = $signed({mat_ff[2*c + r/2][COORD_W-1],
                                     mat_ff[2*c + r/2][COORD_W-1:0]});
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_PLANES; k++) begin
         for (int c = 0; c < 4; c++) begin
            if (k % 2 == 1) begin
               coef[k][c] = elem[3][c] - elem[k/2][c];
            end else begin
               coef[k][c] = elem[3][c] + elem[k/2][c];
            end
         end
         small_ok[k] = 1'b1;
         for (int c = 0; c < 3; c++) begin
            neg_val[k][c] = -coef[k][c];
            mag3[k][c] = coef[k][c][COEF_W-1] ? neg_val[k][c][2:0] : coef[k][c][2:0];
            sq[k][c] = {3'b000, mag3[k][c]} * {3'b000, mag3[k][c]};
            if (coef[k][c] > DEGEN_HI || coef[k][c] < DEGEN_LO) begin
               small_ok[k] = 1'b0;
            end
         end
         norm_sq[k] = {1'b0, sq[k][0]} + {1'b0, sq[k][1]} + {1'b0, sq[k][2]};
         planes_in[k].a     = coef[k][0];
         planes_in[k].b     = coef[k][1];
         planes_in[k].c     = coef[k][2];
         planes_in[k].d     = coef[k][3];
         planes_in[k].degen = small_ok[k] && (norm_sq[k] <= 7'(NORM_SQ_MAX));
      end
   end

   always_ff @(posedge clock) begin
      planes_ff <= planes_in;
   end

   assign planes = planes_ff;

endmodule

// ----- design/fac_plane_lane.sv -----
// One plane's datapath: corner select, products, partial sums and sign test.
module fac_plane_lane (
   input  logic                          clock,
   input  fac_pkg::adv_type              adv,
   input  fac_pkg::plane_type            plane,
   input  logic [fac_pkg::COORD_W-1:0]   box_min_x,
   input  logic [fac_pkg::COORD_W-1:0]   box_min_y,
   input  logic [fac_pkg::COORD_W-1:0]   box_min_z,
   input  logic [fac_pkg::COORD_W-1:0]   box_max_x,
   input  logic [fac_pkg::COORD_W-1:0]   box_max_y,
   input  logic [fac_pkg::COORD_W-1:0]   box_max_z,
   output logic                          plane_ok
);
   import fac_pkg::*;

   logic a_pos, b_pos, c_pos;
   logic signed [COORD_W-1:0] pt_x_in, pt_y_in, pt_z_in;
   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   logic maxy_neg2_ff, maxy_neg3_ff, maxy_neg4_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [SUM_W-1:0] d16_in, d16_ff;
   logic signed [SUM_W-1:0] s01_in, s23_in, s01_ff, s23_ff;
   logic signed [SUM_W:0] total;

   assign a_pos = !plane.a[COEF_W-1] && (|plane.a);
   assign b_pos = !plane.b[COEF_W-1] && (|plane.b);
   assign c_pos = !plane.c[COEF_W-1] && (|plane.c);

   assign pt_x_in = $signed(a_pos ? box_max_x : box_min_x);
   assign pt_y_in = $signed(b_pos ? box_max_y : box_min_y);
   assign pt_z_in = $signed(c_pos ? box_max_z : box_min_z);

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         pt_x_ff      <= pt_x_in;
         pt_y_ff      <= pt_y_in;
         pt_z_ff      <= pt_z_in;
         maxy_neg2_ff <= box_max_y[COORD_W-1];
      end
   end

   assign p0_in  = $signed(plane.a) * pt_x_ff;
   assign p1_in  = $signed(plane.b) * pt_y_ff;
   assign p2_in  = $signed(plane.c) * pt_z_ff;
   assign d16_in = $signed({{(SUM_W-COEF_W-FRAC_W){plane.d[COEF_W-1]}}, plane.d,
                            {FRAC_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         d16_ff       <= d16_in;
         maxy_neg3_ff <= maxy_neg2_ff;
      end
   end

   assign s01_in = $signed({p0_ff[PROD_W-1], p0_ff}) + $signed({p1_ff[PROD_W-1], p1_ff});
   assign s23_in = $signed({p2_ff[PROD_W-1], p2_ff}) + d16_ff;

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         s01_ff       <= s01_in;
         s23_ff       <= s23_in;
         maxy_neg4_ff <= maxy_neg3_ff;
      end
   end

   assign total = $signed({s01_ff[SUM_W-1], s01_ff}) + $signed({s23_ff[SUM_W-1], s23_ff});
   assign plane_ok = plane.degen ? !maxy_neg4_ff : !total[SUM_W];

endmodule

// ----- design/frustum_aabb_cull_core.sv -----
// Frustum culling core: tests boxes against six matrix-derived planes.
//
// Takes one axis-aligned box per clock unless req_stall is high, and returns
// one visible bit per box, in order, offered from the output register. The
// stages are: input register, corner select, eighteen parallel 33x32
// multipliers, two partial sums per plane, and a final sum, sign test and
// six-way AND into the output register. Sustained rate is one box per cycle
// while rsp_stall is low. Empty stages absorb bubbles, so the input keeps
// accepting while a finished result waits on rsp_stall, until all five
// stages hold a box. Plane coefficients are rebuilt into registers from the
// matrix registers after a csr write.
module frustum_aabb_cull_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_x,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_y,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_z,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_x,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_y,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_visible,
   input  logic                             csr_write,
   input  logic [fac_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [fac_pkg::REG_W-1:0]        csr_wdata
);
   import fac_pkg::*;

   plane_type [NUM_PLANES-1:0] planes;
   adv_type adv;
   logic [NUM_PLANES-1:0] lane_ok;

   logic v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic v1_in, v2_in, v3_in, v4_in, vo_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy_o;
   logic [COORD_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic [COORD_W-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic vis_ff, vis_in;

   fac_plane_gen u_plane_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_lane
      fac_plane_lane u_lane (
         .clock     (clock),
         .adv       (adv),
         .plane     (planes[k]),
         .box_min_x (min_x_ff),
         .box_min_y (min_y_ff),
         .box_min_z (min_z_ff),
         .box_max_x (max_x_ff),
         .box_max_y (max_y_ff),
         .box_max_z (max_z_ff),
         .plane_ok  (lane_ok[k])
      );
   end

   // advance a stage when it is empty or its successor advances
   assign rdy_o = !vo_ff || !rsp_stall;
   assign rdy4  = !v4_ff || rdy_o;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;

   assign v1_in = rdy1  ? req_valid : v1_ff;
   assign v2_in = rdy2  ? v1_ff     : v2_ff;
   assign v3_in = rdy3  ? v2_ff     : v3_ff;
   assign v4_in = rdy4  ? v3_ff     : v4_ff;
   assign vo_in = rdy_o ? v4_ff     : vo_ff;

   assign adv.s2 = rdy2 && v1_ff;
   assign adv.s3 = rdy3 && v2_ff;
   assign adv.s4 = rdy4 && v3_ff;

   assign vis_in = &lane_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         min_x_ff <= req_box_min_x;
         min_y_ff <= req_box_min_y;
         min_z_ff <= req_box_min_z;
         max_x_ff <= req_box_max_x;
         max_y_ff <= req_box_max_y;
         max_z_ff <= req_box_max_z;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o && v4_ff) begin
         vis_ff <= vis_in;
      end
   end

   assign req_stall   = !rdy1;
   assign rsp_valid   = vo_ff;
   assign rsp_visible = vis_ff;

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && vo_ff))
      else $error("input stalled with an empty pipeline stage");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> v2_ff)
      else $error("blocked stage lost its item");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      (!v4_ff && !vo_ff) |=> !vo_ff)
      else $error("result appeared without an item in the last stage");

   a_advance_needs_item: assert property (@(posedge clock) disable iff (reset)
      (!adv.s3 || v2_ff) && (!adv.s4 || v3_ff))
      else $error("stage advanced without a valid item");

endmodule
